// ----- rtl/dwip_pkg.sv -----
// Shared widths, constants and types of the dual wheel incremental PID block.
package dwip_pkg;

  // Field widths
  localparam int TGT_W   = 17;
  localparam int CNT_W   = 12;
  localparam int GAIN_W  = 16;
  localparam int CFG_W   = 16;
  localparam int CFG_AW  = 3;
  localparam int ERR_W   = 18;
  localparam int DRV_W   = 17;
  localparam int MAG_W   = 16;
  localparam int IN_W    = 64;
  localparam int OUT_W   = 40;

  // Internal datapath widths
  localparam int RECIP_W = 21;
  localparam int OPA_W   = 13;
  localparam int MA_W    = 19;
  localparam int MB_W    = 22;
  localparam int PROD_W  = MA_W + MB_W;
  localparam int ACC_W   = 36;
  localparam int DELTA_W = ACC_W - 8;
  localparam int U_W     = DELTA_W + 1;
  localparam int SPD_W   = 19;

  // Q16 reciprocals of the speed conversion and count offsets
  localparam logic [RECIP_W-1:0] RECIP_LEFT_ACC  = 21'd1092267;
  localparam logic [RECIP_W-1:0] RECIP_RIGHT_ACC = 21'd985504;
  localparam logic [RECIP_W-1:0] RECIP_BRAKE     = 21'd936229;
  localparam logic [OPA_W-1:0]   OFFSET_LEFT     = 13'd40;
  localparam logic [OPA_W-1:0]   OFFSET_RIGHT    = 13'd46;

  // Reset values of threshold and limit
  localparam logic [CFG_W-1:0] THRESHOLD_RST = 16'd710;
  localparam logic [CFG_W-1:0] LIMIT_RST     = 16'd3500;

  // Configuration register indexes
  typedef enum logic [CFG_AW-1:0] {
    REG_ACC_KP, REG_ACC_KI, REG_ACC_KD,
    REG_BRAKE_KP, REG_BRAKE_KI, REG_BRAKE_KD,
    REG_THRESHOLD, REG_DUTY_LIMIT
  } cfg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] acc_kp;
    logic signed [GAIN_W-1:0] acc_ki;
    logic signed [GAIN_W-1:0] acc_kd;
    logic signed [GAIN_W-1:0] brake_kp;
    logic signed [GAIN_W-1:0] brake_ki;
    logic signed [GAIN_W-1:0] brake_kd;
    logic [CFG_W-1:0]         thr;
    logic [CFG_W-1:0]         lim;
  } cfg_regs_t;

  // Lane status toward the merge stage
  typedef struct packed {
    logic                    idle;
    logic                    done;
    logic signed [DRV_W-1:0] drive;
  } lane_stat_t;

  typedef enum logic [2:0] {
    LS_IDLE, LS_SPEED, LS_ERR, LS_PROP, LS_INTG, LS_DERV, LS_UPD, LS_DONE
  } lane_state_t;

endpackage

// ----- rtl/dwip_cfg.sv -----
// Configuration register file of the dual wheel incremental PID block.
module dwip_cfg import dwip_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  output cfg_regs_t         regs
);

  cfg_regs_t regs_r, regs_nxt;
  cfg_idx_t  idx;

  assign idx  = cfg_idx_t'(cfg_addr);
  assign regs = regs_r;

  // Register decode
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (idx)
        REG_ACC_KP:     regs_nxt.acc_kp   = $signed(cfg_wdata);
        REG_ACC_KI:     regs_nxt.acc_ki   = $signed(cfg_wdata);
        REG_ACC_KD:     regs_nxt.acc_kd   = $signed(cfg_wdata);
        REG_BRAKE_KP:   regs_nxt.brake_kp = $signed(cfg_wdata);
        REG_BRAKE_KI:   regs_nxt.brake_ki = $signed(cfg_wdata);
        REG_BRAKE_KD:   regs_nxt.brake_kd = $signed(cfg_wdata);
        REG_THRESHOLD:  regs_nxt.thr      = cfg_wdata;
        REG_DUTY_LIMIT: regs_nxt.lim      = cfg_wdata;
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '{acc_kp: '0, acc_ki: '0, acc_kd: '0,
                  brake_kp: '0, brake_ki: '0, brake_kd: '0,
                  thr: THRESHOLD_RST, lim: LIMIT_RST};
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule

// ----- rtl/dwip_lane.sv -----
// One wheel lane: speed conversion, error history and incremental PID update.
module dwip_lane import dwip_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [TGT_W-1:0] target,
  input  logic signed [CNT_W-1:0] count,
  input  logic [OPA_W-1:0]        offset,
  input  logic [RECIP_W-1:0]      recip_acc,
  input  cfg_regs_t               cfg,
  input  logic                    release_i,
  output lane_stat_t              stat
);

  lane_state_t state_r, state_nxt;

  logic signed [TGT_W-1:0]  tgt_hold_r;
  logic signed [OPA_W-1:0]  opa_r, opa_nxt;
  logic                     acc_mode_r, acc_mode_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ERR_W-1:0]  err_r, e1_r, e2_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [DRV_W-1:0]  drive_r, drive_nxt;

  // Branch select against the threshold
  logic signed [ERR_W-1:0] tgt_x, thr_x;
  logic signed [OPA_W-1:0] cnt_x, off_x;
  logic                    pos_br, neg_br;

  assign tgt_x  = ERR_W'(target);
  assign thr_x  = $signed(ERR_W'(cfg.thr));
  assign pos_br = tgt_x >= thr_x;
  assign neg_br = tgt_x <= -thr_x;
  assign cnt_x  = OPA_W'(count);
  assign off_x  = $signed(offset);

  always_comb begin
    acc_mode_nxt = pos_br | neg_br;
    if (pos_br)      opa_nxt = cnt_x + off_x;
    else if (neg_br) opa_nxt = cnt_x - off_x;
    else             opa_nxt = cnt_x;
  end

  // Shared multiplier operands
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] mul_p;
  logic signed [GAIN_W-1:0] kp, ki, kd;

  assign kp = acc_mode_r ? cfg.acc_kp : cfg.brake_kp;
  assign ki = acc_mode_r ? cfg.acc_ki : cfg.brake_ki;
  assign kd = acc_mode_r ? cfg.acc_kd : cfg.brake_kd;

  always_comb begin
    mul_a = MA_W'(err_r);
    mul_b = MB_W'(kp);
    case (state_r)
      LS_SPEED: begin
        mul_a = MA_W'(opa_r);
        mul_b = $signed({1'b0, (acc_mode_r ? recip_acc : RECIP_BRAKE)});
      end
      LS_INTG: begin
        mul_a = MA_W'(e1_r);
        mul_b = MB_W'(ki);
      end
      LS_DERV: begin
        mul_a = MA_W'(e2_r);
        mul_b = MB_W'(kd);
      end
      default: begin
        mul_a = MA_W'(err_r);
        mul_b = MB_W'(kp);
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // Speed: product / 65536 truncated toward zero, then error
  logic signed [PROD_W-1:0] spd_bias;
  logic signed [SPD_W-1:0]  spd, err_w;

  assign spd_bias = prod_r + (prod_r[PROD_W-1] ? PROD_W'(65535) : PROD_W'(0));
  assign spd      = spd_bias[16 +: SPD_W];
  assign err_w    = SPD_W'(tgt_hold_r) - spd;

  // Increment: sum / 256 truncated toward zero, accumulate and clamp
  logic signed [ACC_W-1:0]   sum, sum_bias;
  logic signed [DELTA_W-1:0] delta;
  logic signed [U_W-1:0]     u, lim_x;

  assign sum      = acc_r + prod_r[ACC_W-1:0];
  assign sum_bias = sum + (sum[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
  assign delta    = sum_bias[ACC_W-1:8];
  assign u        = U_W'(drive_r) + U_W'(delta);
  assign lim_x    = $signed(U_W'(cfg.lim));

  always_comb begin
    if (u > lim_x)       drive_nxt = DRV_W'(lim_x);
    else if (u < -lim_x) drive_nxt = DRV_W'(-lim_x);
    else                 drive_nxt = DRV_W'(u);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      LS_IDLE:  if (start) state_nxt = LS_SPEED;
      LS_SPEED: state_nxt = LS_ERR;
      LS_ERR:   state_nxt = LS_PROP;
      LS_PROP:  state_nxt = LS_INTG;
      LS_INTG:  state_nxt = LS_DERV;
      LS_DERV:  state_nxt = LS_UPD;
      LS_UPD:   state_nxt = LS_DONE;
      LS_DONE:  if (release_i) state_nxt = LS_IDLE;
      default:  state_nxt = LS_IDLE;
    endcase
  end

  // Status outputs
  always_comb begin
    stat.idle  = (state_r == LS_IDLE);
    stat.done  = (state_r == LS_DONE);
    stat.drive = drive_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= LS_IDLE;
    else        state_r <= state_nxt;
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      LS_IDLE: if (start) begin
        tgt_hold_r <= target;
        opa_r      <= opa_nxt;
        acc_mode_r <= acc_mode_nxt;
      end
      LS_SPEED: prod_r <= mul_p;
      LS_ERR:   err_r  <= err_w[ERR_W-1:0];
      LS_PROP:  prod_r <= mul_p;
      LS_INTG: begin
        acc_r  <= prod_r[ACC_W-1:0];
        prod_r <= mul_p;
      end
      LS_DERV: begin
        acc_r  <= acc_r - prod_r[ACC_W-1:0];
        prod_r <= mul_p;
      end
      default: ;
    endcase
  end

  // Controller state: drive and error history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drive_r <= '0;
      e1_r    <= '0;
      e2_r    <= '0;
    end else if (state_r == LS_UPD) begin
      drive_r <= drive_nxt;
      e2_r    <= e1_r;
      e1_r    <= err_r;
    end
  end

  // Checks
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> (state_r == LS_IDLE))
    else $error("lane started while busy");
  a_upd_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == LS_UPD) |=> (state_r == LS_DONE))
    else $error("update did not finish");
  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == LS_DONE && !release_i) |=> (state_r == LS_DONE) && $stable(drive_r))
    else $error("finished lane lost its result");

endmodule

// ----- rtl/dwip_merge.sv -----
// Merge stage: joins both lane drives into one registered result transfer.
module dwip_merge import dwip_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  lane_stat_t       left_stat,
  input  lane_stat_t       right_stat,
  output logic             release_o,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  logic             valid_r;
  logic [OUT_W-1:0] data_r, data_nxt;
  logic [DRV_W-1:0] mag_left, mag_right;

  // Magnitude plus reverse bit per wheel
  assign mag_left  = left_stat.drive[DRV_W-1]  ? DRV_W'(-left_stat.drive)  : left_stat.drive;
  assign mag_right = right_stat.drive[DRV_W-1] ? DRV_W'(-right_stat.drive) : right_stat.drive;

  assign data_nxt = {{(OUT_W - 2 * (MAG_W + 1)){1'b0}},
                     right_stat.drive[DRV_W-1], mag_right[MAG_W-1:0],
                     left_stat.drive[DRV_W-1],  mag_left[MAG_W-1:0]};

  // Load when both lanes are finished and the slot frees up
  assign release_o  = left_stat.done && right_stat.done && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n)         valid_r <= 1'b0;
    else if (release_o) valid_r <= 1'b1;
    else if (out_tready) valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (release_o) data_r <= data_nxt;
  end

endmodule

// ----- rtl/dual_wheel_incremental_pid_top.sv -----
// Top level of the dual wheel incremental PID speed controller.
//
//  channel | direction | handshake            | payload
//  in_     | slave     | in_tvalid/in_tready  | in_tdata  64 bits
//  out_    | master    | out_tvalid/out_tready| out_tdata 40 bits
//  cfg_    | write     | cfg_we               | cfg_addr 3, cfg_wdata 16
//
// Each tick holds the wheel lanes from its input transfer through the steps
// of the lane's single shared multiplier (speed product, then the three gain
// products) plus error, update and hand-off to the output register; out_tvalid
// rises with that hand-off, which waits while an earlier result is not taken.
// The lanes then return to idle, where they take the next tick.
// A new tick is taken as soon as both lanes have handed their drive to the
// output register, even while that result still waits for out_tready.
// Reset (rst_n low, synchronous) clears drives and error history and restores
// the register defaults.
module dual_wheel_incremental_pid_top import dwip_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // target_left[16:0], target_right[33:17], count_left[45:34], count_right[57:46]
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // left_magnitude[15:0], left_reverse[16], right_magnitude[32:17], right_reverse[33]
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata
);

  cfg_regs_t  regs;
  lane_stat_t left_stat, right_stat;
  logic       start, release_w;

  assign in_tready = left_stat.idle && right_stat.idle;
  assign start     = in_tvalid && in_tready;

  dwip_cfg u_cfg (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata, .regs
  );

  dwip_lane u_lane_left (
    .clk, .rst_n,
    .start     (start),
    .target    ($signed(in_tdata[16:0])),
    .count     ($signed(in_tdata[45:34])),
    .offset    (OFFSET_LEFT),
    .recip_acc (RECIP_LEFT_ACC),
    .cfg       (regs),
    .release_i (release_w),
    .stat      (left_stat)
  );

  dwip_lane u_lane_right (
    .clk, .rst_n,
    .start     (start),
    .target    ($signed(in_tdata[33:17])),
    .count     ($signed(in_tdata[57:46])),
    .offset    (OFFSET_RIGHT),
    .recip_acc (RECIP_RIGHT_ACC),
    .cfg       (regs),
    .release_i (release_w),
    .stat      (right_stat)
  );

  dwip_merge u_merge (
    .clk, .rst_n,
    .left_stat, .right_stat,
    .release_o (release_w),
    .out_tvalid, .out_tready, .out_tdata
  );

endmodule
